/* sv/srp_pkg.sv */
// Shared types, constants and helpers for the stepper speed ramp and period block.
// No dependencies; every other file of the block imports this package.
package srp_pkg;

  // Axis limits and period scale
  localparam int TOP_SPEED  = 15000;
  localparam int TICK_SCALE = 100000;

  // Field and register widths
  localparam int INPUT_W = 20;
  localparam int SPEED_W = 19;
  localparam int MAG_W   = SPEED_W - 1;
  localparam int WIDE_W  = INPUT_W + 1;
  localparam int RES_W   = 32;
  localparam int ACC_W   = 18;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 1;
  localparam int PER_W   = 32;
  localparam int DIR_W   = 2;

  // Speed limit in Q.4
  localparam int SPEED_LIM = TOP_SPEED * 16;

  // Period numerator: 2*TICK_SCALE*R + 4096*|S|, divided by 8192*|S|
  localparam int NUM_SCALE = 2 * TICK_SCALE;
  localparam int SCALE_W   = $clog2(NUM_SCALE + 1);
  localparam int NUM_W     = SCALE_W + RES_W + 1;
  localparam int HALF_SH   = 12;
  localparam int DEN_SH    = 13;
  localparam int QUOT_W    = NUM_W - DEN_SH;
  localparam int CNT_W     = $clog2(QUOT_W + 1);

  localparam logic [PER_W-1:0] PERIOD_MAX = '1;
  localparam logic [RES_W-1:0] RES_RESET  = RES_W'(65536);
  localparam logic [ACC_W-1:0] ACC_RESET  = ACC_W'(16);

  localparam logic signed [DIR_W-1:0] DIR_FWD  = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_REV  = 2'sb11;
  localparam logic signed [DIR_W-1:0] DIR_STOP = 2'sb00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESOLUTION   = 1'b0,
    CFG_ACCELERATION = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_SET  = 1'b0,
    CMD_RAMP = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } srp_state_e;

  // Saturate the quotient to the period width
  function automatic logic [PER_W-1:0] sat_period(input logic [QUOT_W-1:0] q);
    logic [QUOT_W+PER_W-1:0] qx;
    logic [QUOT_W+PER_W-1:0] lim;
    qx  = {{PER_W{1'b0}}, q};
    lim = {{QUOT_W{1'b0}}, PERIOD_MAX};
    if (qx > lim) begin
      return PERIOD_MAX;
    end
    return qx[PER_W-1:0];
  endfunction

endpackage

/* sv/srp_if.sv */
// Valid/ready channel interfaces for speed commands and speed results.
// Depends on srp_pkg for field widths.
interface srp_cmd_if import srp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [INPUT_W-1:0] speed_value;

  modport source (output valid, output command, output speed_value, input ready);
  modport sink   (input valid, input command, input speed_value, output ready);
endinterface

interface srp_res_if import srp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] speed_now;
  logic [PER_W-1:0]          period_ticks;
  logic signed [DIR_W-1:0]   direction;

  modport source (output valid, output speed_now, output period_ticks, output direction,
                  input ready);
  modport sink   (input valid, input speed_now, input period_ticks, input direction,
                  output ready);
endinterface

/* sv/stepper_speed_ramp_period_top.sv */
// Stepper axis speed ramp with step period generation, top level.
// Depends on srp_pkg and the channel interfaces in srp_if.sv.
//
//  channel  dir  payload                                   transfer when
//  cmd_i    in   command, speed_value                      valid & ready
//  res_o    out  speed_now, period_ticks, direction        valid & ready
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_wdata_i          cfg_we_i high
//
// The period comes from a bit-serial restoring divider, one quotient bit a
// cycle; a zero speed skips the divider. The block takes a new command only
// when idle; the result register holds a finished result while the next
// command is accepted, and a stalled result holds the sequencer in its output
// step. Reset clears the speed to zero and loads the register defaults.
module stepper_speed_ramp_period_top import srp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  srp_cmd_if.sink              cmd_i,
  srp_res_if.source            res_o
);

  srp_state_e state_q, state_d;

  logic [RES_W-1:0]          res_q;
  logic [ACC_W-1:0]          acc_q;
  logic signed [SPEED_W-1:0] speed_q, speed_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      out_valid_q, out_valid_d;

  logic [MAG_W-1:0]          mag_q, mag_d;
  logic [NUM_W-1:0]          prod_q, prod_d;
  logic [QUOT_W-1:0]         dvd_q, dvd_d;
  logic [MAG_W-1:0]          rem_q, rem_d;
  logic signed [SPEED_W-1:0] out_speed_q, out_speed_d;
  logic [PER_W-1:0]          out_per_q, out_per_d;
  logic signed [DIR_W-1:0]   out_dir_q, out_dir_d;

  // Ramp arithmetic
  logic signed [WIDE_W-1:0] lim_pos, lim_neg, req, tgt, cur, acc, up, dn, nxt;
  logic signed [SPEED_W-1:0] neg_speed;

  // Scaled resolution
  logic [SCALE_W+RES_W-1:0] scaled_res;

  // Divider step
  logic [MAG_W:0]   rem_sh;
  logic [MAG_W+1:0] diff;
  logic             qbit;
  logic             load;

  // Clamp the request, then set the speed to it or step the speed toward it
  always_comb begin
    lim_pos = WIDE_W'(SPEED_LIM);
    lim_neg = -lim_pos;
    req = WIDE_W'(cmd_i.speed_value);
    if (req > lim_pos) begin
      tgt = lim_pos;
    end else if (req < lim_neg) begin
      tgt = lim_neg;
    end else begin
      tgt = req;
    end
    cur = WIDE_W'(speed_q);
    acc = $signed({{(WIDE_W-ACC_W){1'b0}}, acc_q});
    up  = cur + acc;
    dn  = cur - acc;
    if (cmd_e'(cmd_i.command) == CMD_SET) begin
      nxt = tgt;
    end else if (cur < tgt) begin
      nxt = (up >= tgt) ? tgt : up;
    end else if (cur > tgt) begin
      nxt = (dn <= tgt) ? tgt : dn;
    end else begin
      nxt = cur;
    end
  end

  // Shift-and-subtract step of the period divider
  always_comb begin
    rem_sh = {rem_q, dvd_q[QUOT_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, mag_q};
    qbit   = ~diff[MAG_W+1];
  end

  assign neg_speed  = -speed_q;
  assign scaled_res = SCALE_W'(NUM_SCALE) * res_q;

  // Sequencer and datapath next values
  always_comb begin
    state_d     = state_q;
    speed_d     = speed_q;
    cnt_d       = cnt_q;
    mag_d       = mag_q;
    prod_d      = prod_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    out_speed_d = out_speed_q;
    out_per_d   = out_per_q;
    out_dir_d   = out_dir_q;
    load        = 1'b0;
    cmd_i.ready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        cmd_i.ready = 1'b1;
        if (cmd_i.valid) begin
          speed_d = nxt[SPEED_W-1:0];
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        // take the magnitude and form the scaled resolution
        mag_d  = speed_q[SPEED_W-1] ? neg_speed[MAG_W-1:0] : speed_q[MAG_W-1:0];
        prod_d = NUM_W'(scaled_res);
        state_d = (speed_q == '0) ? ST_OUT : ST_LOAD;
      end
      ST_LOAD: begin
        // add the rounding half and drop the power-of-two part of the divisor
        dvd_d   = QUOT_W'((prod_q + (NUM_W'(mag_q) << HALF_SH)) >> DEN_SH);
        rem_d   = '0;
        cnt_d   = CNT_W'(QUOT_W);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = qbit ? diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];
        dvd_d = {dvd_q[QUOT_W-2:0], qbit};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // hand over once the result register is free
        if (!out_valid_q || res_o.ready) begin
          load        = 1'b1;
          out_speed_d = speed_q;
          if (speed_q == '0) begin
            out_per_d = PERIOD_MAX;
            out_dir_d = DIR_STOP;
          end else begin
            out_per_d = sat_period(dvd_q);
            out_dir_d = speed_q[SPEED_W-1] ? DIR_REV : DIR_FWD;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = load | (out_valid_q & ~res_o.ready);
  end

  // Control registers and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      speed_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      res_q       <= RES_RESET;
      acc_q       <= ACC_RESET;
    end else begin
      state_q     <= state_d;
      speed_q     <= speed_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_RESOLUTION:   res_q <= cfg_wdata_i[RES_W-1:0];
          CFG_ACCELERATION: acc_q <= cfg_wdata_i[ACC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    prod_q      <= prod_d;
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    out_speed_q <= out_speed_d;
    out_per_q   <= out_per_d;
    out_dir_q   <= out_dir_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.speed_now    = out_speed_q;
  assign res_o.period_ticks = out_per_q;
  assign res_o.direction    = out_dir_q;

endmodule

/* sv/srp_checker.sv */
// Port-level checks on the result channel of the speed ramp block.
// Depends on srp_pkg; bound to stepper_speed_ramp_period_top below.
module srp_checker import srp_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      res_valid_i,
  input logic                      res_ready_i,
  input logic signed [SPEED_W-1:0] speed_now_i,
  input logic [PER_W-1:0]          period_ticks_i,
  input logic signed [DIR_W-1:0]   direction_i
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      res_valid_i && $stable(speed_now_i) && $stable(period_ticks_i))
    else $error("stalled result dropped or changed");

  // Direction follows the sign of the speed
  a_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> ((speed_now_i == '0) == (direction_i == DIR_STOP)) &&
                    ((speed_now_i < 0) == (direction_i == DIR_REV)) &&
                    ((speed_now_i > 0) == (direction_i == DIR_FWD)))
    else $error("direction disagrees with speed");

  // Zero speed gives the saturated period
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && speed_now_i == '0 |-> period_ticks_i == PERIOD_MAX)
    else $error("zero speed without saturated period");

  // Speed stays within the top speed
  a_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> (speed_now_i <= SPEED_W'(SPEED_LIM)) &&
                    (speed_now_i >= -SPEED_W'(SPEED_LIM)))
    else $error("speed beyond top speed");

endmodule

bind stepper_speed_ramp_period_top srp_checker u_srp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .speed_now_i    (res_o.speed_now),
  .period_ticks_i (res_o.period_ticks),
  .direction_i    (res_o.direction)
);
